@@ src/cvtd_pkg.sv @@
package cvtd_pkg;

   // History geometry.
   localparam int HISTORY_LEN = 101;
   localparam int COMPARE_LAG = 20;
   localparam int SAMPLE_W    = 16;

   // Pairs at even positions p with p + COMPARE_LAG inside the history.
   localparam int NUM_PAIRS = (HISTORY_LEN - 1 - COMPARE_LAG) / 2 + 1;
   localparam int COUNT_W   = $clog2(NUM_PAIRS + 1);

   // Counts and thresholds are compared at the wider of the two widths.
   localparam int THR_W = 6;
   localparam int CMP_W = (COUNT_W > THR_W) ? COUNT_W : THR_W;

   // Population count tree: groups of eight bits, summed in a second stage.
   localparam int GROUP_SIZE = 8;
   localparam int GROUP_W    = $clog2(GROUP_SIZE + 1);
   localparam int NUM_GROUPS = (NUM_PAIRS + GROUP_SIZE - 1) / GROUP_SIZE;

   // Configuration port.
   localparam int MARGIN_W   = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_THR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCHARGE_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_MARGIN = 2'd2;

   localparam logic [THR_W-1:0]    CHARGE_THR_RESET    = 6'd15;
   localparam logic [THR_W-1:0]    DISCHARGE_THR_RESET = 6'd20;
   localparam logic [MARGIN_W-1:0] CHANGE_MARGIN_RESET = 10'd10;

   // Correction curve.
   localparam int CORR_W = 11;
   localparam logic [SAMPLE_W-1:0] CORR_KNEE_HIGH = 16'd21000;
   localparam logic [SAMPLE_W-1:0] CORR_KNEE_MID  = 16'd13000;
   localparam logic [SAMPLE_W-1:0] CORR_KNEE_LOW  = 16'd5000;
   localparam logic [CORR_W-1:0]   CORR_UNITY     = 11'd1000;
   localparam logic [CORR_W-1:0]   CORR_MID_BASE  = 11'd1128;
   localparam logic [CORR_W-1:0]   CORR_MAX       = 11'd1320;

   // Upper segment: (16 * (21000 - v) + 500) / 1000, done as a multiply by
   // a scaled reciprocal that is exact for every 17 bit numerator.
   localparam logic [14:0] MID_TOP       = 15'd21000;
   localparam logic [16:0] MID_ROUND     = 17'd500;
   localparam logic [17:0] MID_RECIP     = 18'd134218;
   localparam int          MID_SHIFT     = 27;
   // Lower segment: (13000 - v + 25) / 50, exact for every 13 bit numerator.
   localparam logic [13:0] LOW_TOP       = 14'd13025;
   localparam logic [13:0] LOW_RECIP     = 14'd10486;
   localparam int          LOW_SHIFT     = 19;

   typedef struct packed {
      logic rise;
      logic fall;
   } pair_type;

endpackage

@@ src/cvtd_cell.sv @@
module cvtd_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic                           cmp_en,
   input  logic [cvtd_pkg::SAMPLE_W-1:0]  shift_in,
   input  logic [cvtd_pkg::SAMPLE_W-1:0]  lag_in,
   output logic [cvtd_pkg::SAMPLE_W-1:0]  value_out,
   output cvtd_pkg::pair_type             pair_out
);

   logic [cvtd_pkg::SAMPLE_W-1:0] value_ff;
   cvtd_pkg::pair_type            pair_ff;
   cvtd_pkg::pair_type            pair_in;

   // The cell holds one history sample; the older neighbor takes it on a shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (shift_en) begin
         value_ff <= shift_in;
      end
   end

   always_comb begin
      pair_in.rise = value_ff > lag_in;
      pair_in.fall = value_ff < lag_in;
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         pair_ff <= pair_in;
      end
   end

   assign value_out = value_ff;
   assign pair_out  = pair_ff;

endmodule

@@ src/cvtd_popcount.sv @@
module cvtd_popcount (
   input  logic                             clock,
   input  logic                             stage1_en,
   input  logic                             stage2_en,
   input  logic [cvtd_pkg::NUM_PAIRS-1:0]   bits_in,
   output logic [cvtd_pkg::COUNT_W-1:0]     count_out
);

   logic [cvtd_pkg::GROUP_W-1:0] group_ff [cvtd_pkg::NUM_GROUPS];
   logic [cvtd_pkg::GROUP_W-1:0] group_in [cvtd_pkg::NUM_GROUPS];
   logic [cvtd_pkg::COUNT_W-1:0] count_ff;
   logic [cvtd_pkg::COUNT_W-1:0] count_in;

   // First level: each group of eight bits is counted on its own.
   always_comb begin
      for (int g = 0; g < cvtd_pkg::NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int b = 0; b < cvtd_pkg::GROUP_SIZE; b++) begin
            if (g * cvtd_pkg::GROUP_SIZE + b < cvtd_pkg::NUM_PAIRS) begin
               group_in[g] = group_in[g] +
                  cvtd_pkg::GROUP_W'(bits_in[g * cvtd_pkg::GROUP_SIZE + b]);
            end
         end
      end
   end

   always_comb begin
      count_in = '0;
      for (int g = 0; g < cvtd_pkg::NUM_GROUPS; g++) begin
         count_in = count_in + cvtd_pkg::COUNT_W'(group_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage1_en) begin
         group_ff <= group_in;
      end
      if (stage2_en) begin
         count_ff <= count_in;
      end
   end

   assign count_out = count_ff;

endmodule

@@ src/capacitor_voltage_trend_detector.sv @@
// Capacitor voltage trend detector.
// Requests arrive on the req_ channel: one 16 bit voltage sample in millivolts
// per request, accepted when req_valid is high and req_stall is low. Each
// accepted sample is shifted into a chain of history cells, the newest first.
// Every request produces exactly one response on the rsp_ channel: the rise
// and fall counts over the compared sample pairs, the charging and discharging
// flags and the correction factor in thousandths, unity unless discharging.
// A request passes through five steps (shift, pair compare, group count,
// final count, output load), set by the two stage population count and
// the correction multipliers sharing that sequence; rsp_valid rises when
// the output load step registers the response, and that step waits while
// a pending response is stalled. A new request waits until that step ends.
// req_stall is high during reset and while a request is in progress.
// The response sits in an output register; if the receiver stalls, the block
// still accepts and processes the next request and holds it at the output
// load step until the waiting response is taken.
// Reset is synchronous: the history cells clear to zero, the thresholds and
// margin return to 15, 20 and 10, and no response is pending.
// The csr_ port writes one register per cycle and should be used only while
// the block is idle.
module capacitor_voltage_trend_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [15:0]                        req_cap_voltage_mv,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_charging,
   output logic                               rsp_discharging,
   output logic [10:0]                        rsp_correction_permille,
   output logic [5:0]                         rsp_rise_count,
   output logic [5:0]                         rsp_fall_count,
   input  logic                               csr_write_en,
   input  logic [cvtd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cvtd_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_CNT,
      S_SUM,
      S_DONE
   } state_type;

   // Segment of the correction curve that the newest sample falls in.
   typedef enum logic [1:0] {
      SEG_FLAT,
      SEG_MID,
      SEG_LOW,
      SEG_FLOOR
   } segment_type;

   state_type state_ff;

   logic [cvtd_pkg::THR_W-1:0]    charge_thr_ff;
   logic [cvtd_pkg::THR_W-1:0]    discharge_thr_ff;
   logic [cvtd_pkg::MARGIN_W-1:0] margin_ff;

   logic                          accept;
   logic                          out_free;

   logic [cvtd_pkg::SAMPLE_W-1:0] hist_value [cvtd_pkg::HISTORY_LEN];
   cvtd_pkg::pair_type            hist_pair  [cvtd_pkg::HISTORY_LEN];
   logic [cvtd_pkg::NUM_PAIRS-1:0] rise_bits;
   logic [cvtd_pkg::NUM_PAIRS-1:0] fall_bits;
   logic [cvtd_pkg::COUNT_W-1:0]  rise_cnt;
   logic [cvtd_pkg::COUNT_W-1:0]  fall_cnt;

   logic [cvtd_pkg::SAMPLE_W-1:0] newest;
   logic [cvtd_pkg::SAMPLE_W-1:0] oldest;
   logic [cvtd_pkg::SAMPLE_W:0]   up_diff;
   logic [cvtd_pkg::SAMPLE_W:0]   down_diff;
   logic                          gap_up_in;
   logic                          gap_down_in;
   logic                          gap_up_ff;
   logic                          gap_down_ff;

   segment_type                   seg_in;
   segment_type                   seg_ff;
   logic [14:0]                   mid_diff;
   logic [16:0]                   mid_num;
   logic [13:0]                   low_diff;
   logic [34:0]                   mid_prod_in;
   logic [34:0]                   mid_prod_ff;
   logic [26:0]                   low_prod_in;
   logic [26:0]                   low_prod_ff;
   logic [7:0]                    mid_quot;
   logic [7:0]                    low_quot;
   logic [cvtd_pkg::CORR_W-1:0]   corr_in;
   logic [cvtd_pkg::CORR_W-1:0]   corr_ff;

   logic                          chg_in;
   logic                          dis_in;
   logic [cvtd_pkg::CMP_W-1:0]    rise_wide;
   logic [cvtd_pkg::CMP_W-1:0]    fall_wide;

   logic                          rsp_valid_ff;
   logic                          rsp_charging_ff;
   logic                          rsp_discharging_ff;
   logic [cvtd_pkg::CORR_W-1:0]   rsp_corr_ff;
   logic [5:0]                    rsp_rise_ff;
   logic [5:0]                    rsp_fall_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration registers. Writes past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         charge_thr_ff    <= cvtd_pkg::CHARGE_THR_RESET;
         discharge_thr_ff <= cvtd_pkg::DISCHARGE_THR_RESET;
         margin_ff        <= cvtd_pkg::CHANGE_MARGIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            cvtd_pkg::CSR_CHARGE_THR: begin
               charge_thr_ff <= csr_write_data[cvtd_pkg::THR_W-1:0];
            end
            cvtd_pkg::CSR_DISCHARGE_THR: begin
               discharge_thr_ff <= csr_write_data[cvtd_pkg::THR_W-1:0];
            end
            cvtd_pkg::CSR_CHANGE_MARGIN: begin
               margin_ff <= csr_write_data[cvtd_pkg::MARGIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The history chain. Cell 0 takes the new sample; every other cell takes
   // its newer neighbor. A cell at an even position with a partner
   // COMPARE_LAG places older compares against it; the other cells compare
   // against themselves, which never counts.
   genvar i;
   generate
      for (i = 0; i < cvtd_pkg::HISTORY_LEN; i++) begin : g_cell
         logic [cvtd_pkg::SAMPLE_W-1:0] shift_src;
         logic [cvtd_pkg::SAMPLE_W-1:0] lag_src;

         if (i == 0) begin : g_head
            assign shift_src = req_cap_voltage_mv;
         end else begin : g_body
            assign shift_src = hist_value[i-1];
         end

         if ((i % 2 == 0) && (i + cvtd_pkg::COMPARE_LAG <= cvtd_pkg::HISTORY_LEN - 1))
         begin : g_paired
            assign lag_src = hist_value[i + cvtd_pkg::COMPARE_LAG];
         end else begin : g_single
            assign lag_src = hist_value[i];
         end

         cvtd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (accept),
            .cmp_en    (state_ff == S_CMP),
            .shift_in  (shift_src),
            .lag_in    (lag_src),
            .value_out (hist_value[i]),
            .pair_out  (hist_pair[i])
         );
      end

      for (i = 0; i < cvtd_pkg::NUM_PAIRS; i++) begin : g_pair
         assign rise_bits[i] = hist_pair[2*i].rise;
         assign fall_bits[i] = hist_pair[2*i].fall;
      end
   endgenerate

   cvtd_popcount u_rise_count (
      .clock     (clock),
      .stage1_en (state_ff == S_CNT),
      .stage2_en (state_ff == S_SUM),
      .bits_in   (rise_bits),
      .count_out (rise_cnt)
   );

   cvtd_popcount u_fall_count (
      .clock     (clock),
      .stage1_en (state_ff == S_CNT),
      .stage2_en (state_ff == S_SUM),
      .bits_in   (fall_bits),
      .count_out (fall_cnt)
   );

   // Newest versus oldest sample against the margin, in both directions.
   assign newest    = hist_value[0];
   assign oldest    = hist_value[cvtd_pkg::HISTORY_LEN-1];
   assign up_diff   = {1'b0, newest} - {1'b0, oldest};
   assign down_diff = {1'b0, oldest} - {1'b0, newest};
   assign gap_up_in = !up_diff[cvtd_pkg::SAMPLE_W] &&
      (up_diff[cvtd_pkg::SAMPLE_W-1:0] >
       {{(cvtd_pkg::SAMPLE_W-cvtd_pkg::MARGIN_W){1'b0}}, margin_ff});
   assign gap_down_in = !down_diff[cvtd_pkg::SAMPLE_W] &&
      (down_diff[cvtd_pkg::SAMPLE_W-1:0] >
       {{(cvtd_pkg::SAMPLE_W-cvtd_pkg::MARGIN_W){1'b0}}, margin_ff});

   // Correction curve. Both rounded divisions are multiplications by a
   // scaled reciprocal; the products are registered before the shift.
   always_comb begin
      if (newest > cvtd_pkg::CORR_KNEE_HIGH) begin
         seg_in = SEG_FLAT;
      end else if (newest > cvtd_pkg::CORR_KNEE_MID) begin
         seg_in = SEG_MID;
      end else if (newest > cvtd_pkg::CORR_KNEE_LOW) begin
         seg_in = SEG_LOW;
      end else begin
         seg_in = SEG_FLOOR;
      end
   end

   assign mid_diff    = cvtd_pkg::MID_TOP - newest[14:0];
   assign mid_num     = {mid_diff[12:0], 4'b0000} + cvtd_pkg::MID_ROUND;
   assign low_diff    = cvtd_pkg::LOW_TOP - newest[13:0];
   assign mid_prod_in = mid_num * cvtd_pkg::MID_RECIP;
   assign low_prod_in = low_diff[12:0] * cvtd_pkg::LOW_RECIP;
   assign mid_quot    = mid_prod_ff[cvtd_pkg::MID_SHIFT +: 8];
   assign low_quot    = low_prod_ff[cvtd_pkg::LOW_SHIFT +: 8];

   always_comb begin
      unique case (seg_ff)
         SEG_FLAT:  corr_in = cvtd_pkg::CORR_UNITY;
         SEG_MID:   corr_in = cvtd_pkg::CORR_UNITY + cvtd_pkg::CORR_W'(mid_quot);
         SEG_LOW:   corr_in = cvtd_pkg::CORR_MID_BASE + cvtd_pkg::CORR_W'(low_quot);
         SEG_FLOOR: corr_in = cvtd_pkg::CORR_MAX;
         default:   corr_in = cvtd_pkg::CORR_UNITY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CMP) begin
         gap_up_ff   <= gap_up_in;
         gap_down_ff <= gap_down_in;
         seg_ff      <= seg_in;
         mid_prod_ff <= mid_prod_in;
         low_prod_ff <= low_prod_in;
      end
      if (state_ff == S_CNT) begin
         corr_ff <= corr_in;
      end
   end

   // Flags from the final counts.
   assign rise_wide = cvtd_pkg::CMP_W'(rise_cnt);
   assign fall_wide = cvtd_pkg::CMP_W'(fall_cnt);
   assign chg_in    = (rise_wide > cvtd_pkg::CMP_W'(charge_thr_ff)) && gap_up_ff;
   assign dis_in    = (fall_wide > cvtd_pkg::CMP_W'(discharge_thr_ff)) && gap_down_ff;

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the output load step a taken response is replaced by the next
         // one, so the valid is cleared only outside that step.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               state_ff <= S_CNT;
            end
            S_CNT: begin
               state_ff <= S_SUM;
            end
            S_SUM: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_charging_ff    <= chg_in;
                  rsp_discharging_ff <= dis_in;
                  rsp_corr_ff        <= dis_in ? corr_ff : cvtd_pkg::CORR_UNITY;
                  rsp_rise_ff        <= rise_wide[5:0];
                  rsp_fall_ff        <= fall_wide[5:0];
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_charging            = rsp_charging_ff;
   assign rsp_discharging         = rsp_discharging_ff;
   assign rsp_correction_permille = rsp_corr_ff;
   assign rsp_rise_count          = rsp_rise_ff;
   assign rsp_fall_count          = rsp_fall_ff;

   // A new response appears only out of the output load step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("response appeared outside the output load step");

   // An accepted request always starts the compare step next.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CMP))
      else $error("accepted request did not start the sequence");

   // A pair is a rise, a fall or neither, so the counts never exceed the pairs.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |->
         ((int'(rise_cnt) + int'(fall_cnt)) <= cvtd_pkg::NUM_PAIRS))
      else $error("rise and fall counts exceed the number of pairs");

   // Charging and discharging need opposite signs of the same difference.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_charging && rsp_discharging))
      else $error("charging and discharging flagged together");

   // Without discharge the correction is unity.
   a_unity_corr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_discharging) |->
         (rsp_correction_permille == cvtd_pkg::CORR_UNITY))
      else $error("correction not unity outside discharge");

endmodule
